/* sv/bitsliced_64bit_block_encrypt_macros.svh */
// assertion macros for the checker file sv/pipo_chk.sv
`ifndef BITSLICED_64BIT_BLOCK_ENCRYPT_MACROS_SVH
`define BITSLICED_64BIT_BLOCK_ENCRYPT_MACROS_SVH

// property sampled on the rising clock edge, off while reset is high
`define PIPO_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define PIPO_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/pipo_pkg.sv */
package pipo_pkg;

   localparam int ROUNDS  = 13;
   localparam int RND_W   = $clog2(ROUNDS + 1);
   localparam int BLK_W   = 64;
   localparam int PADDR_W = 4;
   localparam int PDATA_W = 64;

   // register byte addresses
   localparam logic [PADDR_W-1:0] ADDR_KEY_LOW  = PADDR_W'(0);
   localparam logic [PADDR_W-1:0] ADDR_KEY_HIGH = PADDR_W'(8);

   // left rotate amount for each byte slice
   localparam logic [2:0] ROT_AMT [8] = '{3'd0, 3'd7, 3'd4, 3'd3, 3'd6, 3'd5, 3'd1, 3'd2};

   typedef struct packed {
      logic             valid;
      logic [BLK_W-1:0] data;
   } stage_type;

   function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] r);
      logic [15:0] d;
      d = {v, v} << r;
      return d[15:8];
   endfunction

   function automatic logic [BLK_W-1:0] sched_key(input logic [BLK_W-1:0] lo,
                                                  input logic [BLK_W-1:0] hi,
                                                  input logic [RND_W-1:0] r);
      logic [BLK_W-1:0] rk;
      rk = r[0] ? hi : lo;
      rk[7:0] = rk[7:0] ^ 8'(r);
      return rk;
   endfunction

   // bitsliced s-box over the eight byte slices, then per-byte rotation
   function automatic logic [BLK_W-1:0] sbox_perm(input logic [BLK_W-1:0] blk);
      logic [7:0] x [8];
      logic [7:0] t0, t1, t2;
      logic [BLK_W-1:0] res;
      for (int k = 0; k < 8; k++) x[k] = blk[8*k +: 8];
      // first 5-bit layer
      x[5] = x[5] ^ (x[7] & x[6]);
      x[4] = x[4] ^ (x[3] & x[5]);
      x[7] = x[7] ^ x[4];
      x[6] = x[6] ^ x[3];
      x[3] = x[3] ^ (x[4] | x[5]);
      x[5] = x[5] ^ x[7];
      x[4] = x[4] ^ (x[5] & x[6]);
      // 3-bit layer
      x[2] = x[2] ^ (x[1] & x[0]);
      x[0] = x[0] ^ (x[2] | x[1]);
      x[1] = x[1] ^ (x[2] | x[0]);
      x[2] = ~x[2];
      // extension
      x[7] = x[7] ^ x[1];
      x[3] = x[3] ^ x[2];
      x[4] = x[4] ^ x[0];
      // second 5-bit layer
      t0 = x[7];
      t1 = x[3];
      t2 = x[4];
      x[6] = x[6] ^ (t0 & x[5]);
      t0 = t0 ^ x[6];
      x[6] = x[6] ^ (t2 | t1);
      t1 = t1 ^ x[5];
      x[5] = x[5] ^ (x[6] | t2);
      t2 = t2 ^ (t1 & t0);
      // truncation and slice swap
      x[2] = x[2] ^ t0;
      t0 = x[1] ^ t2;
      x[1] = x[0] ^ t1;
      x[0] = x[7];
      x[7] = t0;
      t1 = x[3];
      x[3] = x[6];
      x[6] = t1;
      t2 = x[4];
      x[4] = x[5];
      x[5] = t2;
      for (int k = 0; k < 8; k++) res[8*k +: 8] = rotl8(x[k], ROT_AMT[k]);
      return res;
   endfunction

endpackage

/* sv/pipo_csr.sv */
module pipo_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [pipo_pkg::PADDR_W-1:0]  paddr,
   input  logic [pipo_pkg::PDATA_W-1:0]  pwdata,
   output logic [pipo_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready,
   output logic [pipo_pkg::BLK_W-1:0]    key_low,
   output logic [pipo_pkg::BLK_W-1:0]    key_high
);
   import pipo_pkg::*;

   logic [BLK_W-1:0] key_low_ff, key_high_ff;
   logic             wr_en;

   // low address bits are ignored, bit 3 picks the register
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign prdata = paddr[3] ? key_high_ff : key_low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else if (wr_en) begin
         if (paddr[3] == ADDR_KEY_HIGH[3]) begin
            key_high_ff <= pwdata;
         end else begin
            key_low_ff <= pwdata;
         end
      end
   end

   assign key_low  = key_low_ff;
   assign key_high = key_high_ff;

endmodule

/* sv/pipo_round.sv */
module pipo_round (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic [pipo_pkg::BLK_W-1:0] rkey,
   input  pipo_pkg::stage_type        stage_prev,
   output pipo_pkg::stage_type        stage_out
);
   import pipo_pkg::*;

   logic             valid_ff;
   logic [BLK_W-1:0] data_ff, data_in;

   assign data_in = sbox_perm(stage_prev.data) ^ rkey;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= stage_prev.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign stage_out.valid = valid_ff;
   assign stage_out.data  = data_ff;

endmodule

/* sv/bitsliced_64bit_block_encrypt.sv */
// PIPO-64/128 encryption, fully unrolled: one register stage for the key-0 whitening and one
// per round (13), so a block goes in every cycle when nothing stalls, passing the whitening
// register and then each round register; the last round register is the output register. Each
// stage moves on when it is empty or when the stage after it moves, so a stall on the result
// side fills bubbles first and only stops the input side once all 14 stages hold blocks. The two
// 64-bit key halves sit at byte addresses 0 (low) and 8 (high) of the register port and are read
// live by every stage, so they are only to be written while no block is in flight.
module bitsliced_64bit_block_encrypt (
   input  logic                          clock,
   input  logic                          reset,
   // input transfer
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pipo_pkg::BLK_W-1:0]    req_plain_block,
   // result transfer
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pipo_pkg::BLK_W-1:0]    rsp_cipher_block,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [pipo_pkg::PADDR_W-1:0]  paddr,
   input  logic [pipo_pkg::PDATA_W-1:0]  pwdata,
   output logic [pipo_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready
);
   import pipo_pkg::*;

   logic [BLK_W-1:0] key_low, key_high;

   // stage 0 is the whitening register, stages 1..ROUNDS the rounds
   stage_type        stage [ROUNDS+1];
   logic [ROUNDS+1:0] ready;

   logic             wh_valid_ff;
   logic [BLK_W-1:0] wh_data_ff, wh_data_in;

   pipo_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .key_low  (key_low),
      .key_high (key_high)
   );

   // ready ripples back from the output: a stage may load when empty or when it drains
   always_comb begin
      ready[ROUNDS+1] = !rsp_stall;
      for (int i = ROUNDS; i >= 0; i--) begin
         ready[i] = !stage[i].valid || ready[i+1];
      end
   end

   assign req_stall = !ready[0];

   // whitening with round key 0
   assign wh_data_in = req_plain_block ^ sched_key(key_low, key_high, RND_W'(0));

   always_ff @(posedge clock) begin
      if (reset) begin
         wh_valid_ff <= 1'b0;
      end else if (ready[0]) begin
         wh_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         wh_data_ff <= wh_data_in;
      end
   end

   assign stage[0].valid = wh_valid_ff;
   assign stage[0].data  = wh_data_ff;

   // one round per stage
   for (genvar r = 1; r <= ROUNDS; r++) begin : g_round
      pipo_round u_round (
         .clock      (clock),
         .reset      (reset),
         .load       (ready[r]),
         .rkey       (sched_key(key_low, key_high, RND_W'(r))),
         .stage_prev (stage[r-1]),
         .stage_out  (stage[r])
      );
   end

   // last round register drives the result transfer
   assign rsp_valid        = stage[ROUNDS].valid;
   assign rsp_cipher_block = stage[ROUNDS].data;

endmodule

/* sv/pipo_chk.sv */
`include "bitsliced_64bit_block_encrypt_macros.svh"

module pipo_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [pipo_pkg::BLK_W-1:0]    rsp_cipher_block,
   input logic                          pready
);
   import pipo_pkg::*;

   // a held result keeps its value
   `PIPO_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
                     rsp_valid && $stable(rsp_cipher_block), "result changed while stalled")

   // input is only stalled when the output holds a result and is blocked
   `PIPO_ASSERT(a_stall_full, req_stall |-> (rsp_valid && rsp_stall), "input stalled early")

   // an open output always lets the input move
   `PIPO_ASSERT(a_flow, !rsp_stall |-> !req_stall, "input stalled while output drains")

   // register port never waits
   `PIPO_ASSERT(a_pready, pready, "register port not ready")

endmodule

bind bitsliced_64bit_block_encrypt pipo_chk u_pipo_chk (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_cipher_block (rsp_cipher_block),
   .pready           (pready)
);

/* tb/bitsliced_64bit_block_encrypt_checker.sv */
`timescale 1ns / 1ps

module bitsliced_64bit_block_encrypt_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [pipo_pkg::BLK_W-1:0]    req_plain_block,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [pipo_pkg::BLK_W-1:0]    rsp_cipher_block,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [pipo_pkg::PADDR_W-1:0]  paddr,
   input  logic [pipo_pkg::PDATA_W-1:0]  pwdata,
   input  logic                          pready,
   output int                            mismatch_count,
   output int                            blocks_in_flight
);

   localparam int ROL_BY [8] = '{0, 7, 4, 3, 6, 5, 1, 2};

   logic [63:0] key_lo_copy;
   logic [63:0] key_hi_copy;
   logic [63:0] cipher_due [$];

   function automatic logic [63:0] pipo_encrypt(input logic [63:0] plain,
                                                input logic [63:0] k_lo,
                                                input logic [63:0] k_hi);
      logic [7:0]  s [8];
      logic [7:0]  a, b, c;
      logic [63:0] rk;
      logic [63:0] res;
      // whitening with round key 0
      for (int k = 0; k < 8; k++) s[k] = plain[8*k +: 8] ^ k_lo[8*k +: 8];
      for (int rnd = 1; rnd <= pipo_pkg::ROUNDS; rnd++) begin
         // 5-bit part
         s[5] = s[5] ^ (s[7] & s[6]);
         s[4] = s[4] ^ (s[3] & s[5]);
         s[7] = s[7] ^ s[4];
         s[6] = s[6] ^ s[3];
         s[3] = s[3] ^ (s[4] | s[5]);
         s[5] = s[5] ^ s[7];
         s[4] = s[4] ^ (s[5] & s[6]);
         // 3-bit part
         s[2] = s[2] ^ (s[1] & s[0]);
         s[0] = s[0] ^ (s[2] | s[1]);
         s[1] = s[1] ^ (s[2] | s[0]);
         s[2] = ~s[2];
         s[7] = s[7] ^ s[1];
         s[3] = s[3] ^ s[2];
         s[4] = s[4] ^ s[0];
         // second 5-bit part
         a = s[7];
         b = s[3];
         c = s[4];
         s[6] = s[6] ^ (a & s[5]);
         a = a ^ s[6];
         s[6] = s[6] ^ (c | b);
         b = b ^ s[5];
         s[5] = s[5] ^ (s[6] | c);
         c = c ^ (b & a);
         // truncation and slice reorder
         s[2] = s[2] ^ a;
         a = s[1] ^ c;
         s[1] = s[0] ^ b;
         s[0] = s[7];
         s[7] = a;
         b = s[3];
         s[3] = s[6];
         s[6] = b;
         c = s[4];
         s[4] = s[5];
         s[5] = c;
         // per-byte rotate, then round key with its counter in the low byte
         rk = rnd[0] ? k_hi : k_lo;
         rk[7:0] = rk[7:0] ^ 8'(rnd);
         for (int k = 0; k < 8; k++) begin
            s[k] = (s[k] << ROL_BY[k]) | (s[k] >> (8 - ROL_BY[k]));
            s[k] = s[k] ^ rk[8*k +: 8];
         end
      end
      for (int k = 0; k < 8; k++) res[8*k +: 8] = s[k];
      return res;
   endfunction

   initial begin
      mismatch_count   = 0;
      blocks_in_flight = 0;
      key_lo_copy      = '0;
      key_hi_copy      = '0;
   end

   always @(posedge clock) begin
      if (reset) begin
         cipher_due.delete();
         key_lo_copy = '0;
         key_hi_copy = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (cipher_due.size() == 0) begin
               $display("%0t: cipher_block %h arrived with nothing pending",
                        $time, rsp_cipher_block);
               mismatch_count++;
            end else begin
               if (rsp_cipher_block !== cipher_due[0]) begin
                  $display("%0t: cipher_block mismatch, expected %h, got %h",
                           $time, cipher_due[0], rsp_cipher_block);
                  mismatch_count++;
               end
               void'(cipher_due.pop_front());
            end
         end
         if (req_valid && !req_stall)
            cipher_due.push_back(pipo_encrypt(req_plain_block, key_lo_copy, key_hi_copy));
         if (psel && penable && pwrite && pready) begin
            if (paddr == pipo_pkg::ADDR_KEY_LOW)
               key_lo_copy = pwdata;
            else if (paddr == pipo_pkg::ADDR_KEY_HIGH)
               key_hi_copy = pwdata;
         end
      end
      blocks_in_flight = cipher_due.size();
   end

endmodule

/* tb/bitsliced_64bit_block_encrypt_tb.sv */
`timescale 1ns / 1ps

module bitsliced_64bit_block_encrypt_tb;

   // 14 register stages from plaintext to ciphertext, plus some slack
   localparam int PIPE_DRAIN    = 20;
   // cycles with no transfer on either channel before the run is declared hung
   localparam int STUCK_LIMIT   = 5000;
   localparam int PHASE_BLOCKS  = 125;
   localparam int KEY_SETS      = 6;
   // the key set during which neither side idles
   localparam int CALM_SET      = 3;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [pipo_pkg::BLK_W-1:0]    req_plain_block = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [pipo_pkg::BLK_W-1:0]    rsp_cipher_block;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [pipo_pkg::PADDR_W-1:0]  paddr = '0;
   logic [pipo_pkg::PDATA_W-1:0]  pwdata = '0;
   logic [pipo_pkg::PDATA_W-1:0]  prdata;
   logic                          pready;

   int   mismatch_count;
   int   blocks_in_flight;
   int   stuck_cycles = 0;
   logic calm = 1'b0;

   bitsliced_64bit_block_encrypt DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_plain_block  (req_plain_block),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cipher_block (rsp_cipher_block),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // watches both channels and the register port, predicts every ciphertext
   bitsliced_64bit_block_encrypt_checker u_cipher_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_plain_block  (req_plain_block),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cipher_block (rsp_cipher_block),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .pready           (pready),
      .mismatch_count   (mismatch_count),
      .blocks_in_flight (blocks_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result side: random stalls, never during the calm stretch
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 6);
   end

   // hang detection: any transfer on either channel restarts the count
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic logic [63:0] any_block();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(9))
         // single set bit
         0: v = 64'd1 << $urandom_range(63);
         // whole bytes of zeros and ones, stresses the column-wise s-box
         1: for (int k = 0; k < 8; k++) v[8*k +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
         // single cleared bit
         2: v = ~(64'd1 << $urandom_range(63));
         default: ;
      endcase
      return v;
   endfunction

   // register write: setup cycle, then access cycle, then an idle bus before the task returns
   task automatic write_reg(input logic [pipo_pkg::PADDR_W-1:0] addr,
                            input logic [pipo_pkg::PDATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // one plaintext transfer, sometimes after an idle cycle with junk on the bus
   task automatic offer_plaintext(input logic [63:0] blk);
      if (!calm && $urandom_range(99) < 6) begin
         req_valid       <= 1'b0;
         req_plain_block <= {$urandom, $urandom};
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_plain_block <= blk;
      do @(posedge clock); while (req_stall);
   endtask

   // keys are read live by every stage, so the pipe must be empty before a key write
   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (blocks_in_flight != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   initial begin
      logic [63:0] directed [$];
      logic [63:0] lo_set [KEY_SETS];
      logic [63:0] hi_set [KEY_SETS];

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed blocks under the reset keys (both halves zero)
      directed = '{64'h0, ~64'h0, 64'h1, 64'h8000_0000_0000_0000,
                   64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                   64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                   64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0};
      for (int k = 0; k < 8; k++) directed.push_back(64'hFF << (8 * k));
      foreach (directed[i]) offer_plaintext(directed[i]);
      drain_pipe();

      // key settings: all ones, low-byte extremes where the round counter lands,
      // random ones, and one half zero with the other all ones
      lo_set[0] = ~64'h0;
      hi_set[0] = ~64'h0;
      lo_set[1] = 64'h0000_0000_0000_00FF;
      hi_set[1] = 64'hFFFF_FFFF_FFFF_FF00;
      for (int s = 2; s < 5; s++) begin
         lo_set[s] = {$urandom, $urandom};
         hi_set[s] = {$urandom, $urandom};
      end
      lo_set[5] = 64'h0;
      hi_set[5] = ~64'h0;

      for (int s = 0; s < KEY_SETS; s++) begin
         write_reg(pipo_pkg::ADDR_KEY_LOW, lo_set[s]);
         write_reg(pipo_pkg::ADDR_KEY_HIGH, hi_set[s]);
         calm <= (s == CALM_SET);
         // a couple of extreme blocks under every key pair, then random ones
         offer_plaintext(64'h0);
         offer_plaintext(~64'h0);
         for (int n = 0; n < PHASE_BLOCKS; n++) offer_plaintext(any_block());
         drain_pipe();
         calm <= 1'b0;
      end

      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/pipo_pkg.sv
sv/pipo_csr.sv
sv/pipo_round.sv
sv/bitsliced_64bit_block_encrypt.sv
sv/pipo_chk.sv
tb/bitsliced_64bit_block_encrypt_checker.sv
tb/bitsliced_64bit_block_encrypt_tb.sv
